[hw/rtl/mfmi_pkg.sv]
// ----------------------------------------------------------------------------
// mfmi_pkg
// Shared opcodes and the queued command word of the frame match inserter.
// ----------------------------------------------------------------------------
package mfmi_pkg;

  localparam logic [2:0] OP_HEADER    = 3'd0;
  localparam logic [2:0] OP_REPLY     = 3'd1;
  localparam logic [2:0] OP_RD_PAT    = 3'd2;
  localparam logic [2:0] OP_TG_PAT    = 3'd3;
  localparam logic [2:0] OP_RD_FRAME  = 3'd4;
  localparam logic [2:0] OP_TG_FRAME  = 3'd5;
  localparam logic [2:0] OP_MATCH     = 3'd6;

  localparam int SLOT_BYTES = 64;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] rule_index;
    logic [5:0] position;
    logic [7:0] value;
    logic       ign_hi;
    logic       ign_lo;
    logic [6:0] rd_len;
    logic [6:0] tg_len;
    logic       crc;
    logic       fix;
    logic       last;
    logic       nbz;
  } cmd_t;

endpackage

[hw/rtl/mfmi_front.sv]
// ----------------------------------------------------------------------------
// mfmi_front
// Input side: takes words, drops those that do nothing, queues the rest.
// ----------------------------------------------------------------------------
module mfmi_front #(
  parameter int NRULE = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mfmi_pkg::cmd_t  in_cmd,
  output logic            q_valid,
  output mfmi_pkg::cmd_t  q_cmd,
  input  logic            q_pop
);

  mfmi_pkg::cmd_t slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       push;

  // opcode 7 and out-of-range rule writes have no effect
  always_comb begin
    keep = 1'b1;
    unique case (in_cmd.opcode)
      mfmi_pkg::OP_HEADER, mfmi_pkg::OP_REPLY, mfmi_pkg::OP_RD_PAT,
      mfmi_pkg::OP_TG_PAT:
        keep = (32'(in_cmd.rule_index) < NRULE);
      mfmi_pkg::OP_RD_FRAME, mfmi_pkg::OP_TG_FRAME, mfmi_pkg::OP_MATCH:
        keep = 1'b1;
      default:
        keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push  ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= in_cmd;
    end
  end

endmodule

[hw/rtl/mfmi_back.sv]
// ----------------------------------------------------------------------------
// mfmi_back
// Executes queued words: table and frame writes, and the rule walk.
// ----------------------------------------------------------------------------
module mfmi_back #(
  parameter int NRULE       = 16,
  parameter int FRAME_BYTES = 64,
  parameter int REPLY_BYTES = 62
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  mfmi_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_last_res,
  output logic            out_matched,
  output logic [3:0]      out_matched_rule,
  output logic [6:0]      out_frame_length
);

  localparam int RIW   = (NRULE > 1) ? $clog2(NRULE) : 1;
  localparam int RCW   = $clog2(NRULE + 1);
  localparam int FA    = $clog2(FRAME_BYTES);
  localparam int FL    = $clog2(FRAME_BYTES + 1);
  localparam int MA    = RIW + 6;
  localparam int DEPTH = NRULE * mfmi_pkg::SLOT_BYTES;

  typedef struct packed {
    logic [5:0] reply_len;
    logic [6:0] rd_len;
    logic [6:0] tg_len;
    logic       crc;
    logic       fix;
  } hdr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_PISSUE, S_PCMP, S_ERD, S_EOUT, S_CLO, S_CHI, S_EMPTY,
    S_NOMATCH, S_DONE
  } state_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [7:0] ch;
    begin
      ch = d ^ c[7:0];
      ch = ch ^ {ch[3:0], 4'd0};
      crc_step = {8'd0, c[15:8]} ^ {ch, 8'd0} ^ {5'd0, ch, 3'd0} ^ {12'd0, ch[7:4]};
    end
  endfunction

  hdr_t        hdr_r [NRULE];
  logic [7:0]  reply_mem [DEPTH];
  logic [9:0]  rpat_mem [DEPTH];
  logic [9:0]  tpat_mem [DEPTH];
  logic [7:0]  rframe_mem [FRAME_BYTES];
  logic [7:0]  tframe_mem [FRAME_BYTES];

  logic [7:0]  reply_q;
  logic [9:0]  rpat_q, tpat_q;
  logic [7:0]  rframe_q, tframe_q;

  state_t      state_r;
  logic [RCW-1:0] rule_r;
  logic [6:0]  j_r;
  logic [6:0]  plen_r;
  logic        side_r;
  logic [5:0]  k_r;
  logic [15:0] crc_r;
  logic        nbz_r;
  logic [FL-1:0] rlen_r, tlen_r;
  logic        ropen_r, topen_r;

  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r;
  logic        olast_r, omatch_r;
  logic [3:0]  orule_r;
  logic [6:0]  olen_r;

  hdr_t        h;
  logic [RIW-1:0] ridx;
  logic [6:0]  total;
  logic        out_free;
  logic [7:0]  ebyte;
  logic [7:0]  fbyte;
  logic [9:0]  pbyte;
  logic        pmatch;

  // reader frame write port, shared by frame loading and reply copy-back
  logic        rf_we;
  logic [FA-1:0] rf_addr;
  logic [7:0]  rf_data;
  logic        tf_we;
  logic [FL-1:0] push_len;

  assign ridx     = rule_r[RIW-1:0];
  assign h        = hdr_r[ridx];
  assign total    = 7'(h.reply_len) + (h.crc ? 7'd2 : 7'd0);
  assign out_free = !ovalid_r || out_ready;

  // output word loaded by any emitting state, held until taken
  assign ovalid_nxt = (ovalid_r && !out_ready) ||
                      (out_free && (state_r inside {S_EOUT, S_CLO, S_CHI, S_EMPTY,
                                                    S_NOMATCH}));

  // with fix set, the first reply byte gets its block-number bits rewritten
  always_comb begin
    ebyte = reply_q;
    if (h.fix && k_r == 6'd0) begin
      ebyte = nbz_r ? ((reply_q & 8'hFE) | 8'h02) : (reply_q | 8'h03);
    end
  end

  always_comb begin
    fbyte = side_r ? tframe_q : rframe_q;
    pbyte = side_r ? tpat_q : rpat_q;
    if (pbyte[8]) fbyte = fbyte & 8'h0F;
    if (pbyte[9]) fbyte = fbyte & 8'hF0;
    pmatch = (fbyte == pbyte[7:0]);
  end

  always_comb begin
    q_pop    = (state_r == S_IDLE) && q_valid;
    push_len = (q_cmd.opcode == mfmi_pkg::OP_RD_FRAME) ?
               (ropen_r ? rlen_r : '0) : (topen_r ? tlen_r : '0);
    rf_we    = 1'b0;
    rf_addr  = FA'(push_len);
    rf_data  = q_cmd.value;
    tf_we    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        rf_we = q_valid && q_cmd.opcode == mfmi_pkg::OP_RD_FRAME &&
                32'(push_len) < FRAME_BYTES;
        tf_we = q_valid && q_cmd.opcode == mfmi_pkg::OP_TG_FRAME &&
                32'(push_len) < FRAME_BYTES;
      end
      S_EOUT: begin
        rf_we   = out_free && 32'(k_r) < FRAME_BYTES;
        rf_addr = FA'(k_r);
        rf_data = ebyte;
      end
      S_CLO: begin
        rf_we   = out_free && 32'(h.reply_len) < FRAME_BYTES;
        rf_addr = FA'(h.reply_len);
        rf_data = crc_r[7:0];
      end
      S_CHI: begin
        rf_we   = out_free && 32'(h.reply_len) + 1 < FRAME_BYTES;
        rf_addr = FA'(7'(h.reply_len) + 7'd1);
        rf_data = crc_r[15:8];
      end
      default: begin
        rf_we = 1'b0;
      end
    endcase
  end

  // memories, read data registered
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.opcode == mfmi_pkg::OP_REPLY)
      reply_mem[{q_cmd.rule_index[RIW-1:0], q_cmd.position}] <= q_cmd.value;
    reply_q <= reply_mem[{ridx, k_r}];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.opcode == mfmi_pkg::OP_RD_PAT)
      rpat_mem[{q_cmd.rule_index[RIW-1:0], q_cmd.position}] <=
        {q_cmd.ign_lo, q_cmd.ign_hi, q_cmd.value};
    rpat_q <= rpat_mem[MA'({ridx, j_r[5:0]})];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.opcode == mfmi_pkg::OP_TG_PAT)
      tpat_mem[{q_cmd.rule_index[RIW-1:0], q_cmd.position}] <=
        {q_cmd.ign_lo, q_cmd.ign_hi, q_cmd.value};
    tpat_q <= tpat_mem[MA'({ridx, j_r[5:0]})];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rframe_mem[rf_addr] <= rf_data;
    rframe_q <= rframe_mem[FA'(j_r)];
  end

  always_ff @(posedge clk) begin
    if (tf_we) tframe_mem[FA'(push_len)] <= q_cmd.value;
    tframe_q <= tframe_mem[FA'(j_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NRULE; i++) hdr_r[i] <= '0;
    end else if (q_pop && q_cmd.opcode == mfmi_pkg::OP_HEADER) begin
      hdr_r[q_cmd.rule_index[RIW-1:0]] <= '{
        reply_len: (32'(q_cmd.value) > REPLY_BYTES) ? 6'(REPLY_BYTES) : q_cmd.value[5:0],
        rd_len:    q_cmd.rd_len,
        tg_len:    q_cmd.tg_len,
        crc:       q_cmd.crc,
        fix:       q_cmd.fix
      };
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rule_r   <= '0;
      j_r      <= '0;
      plen_r   <= '0;
      side_r   <= 1'b0;
      k_r      <= '0;
      crc_r    <= 16'h6363;
      nbz_r    <= 1'b0;
      rlen_r   <= '0;
      tlen_r   <= '0;
      ropen_r  <= 1'b0;
      topen_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.opcode == mfmi_pkg::OP_RD_FRAME) begin
              rlen_r  <= (32'(push_len) < FRAME_BYTES) ? push_len + 1'b1 : push_len;
              ropen_r <= !q_cmd.last;
            end
            if (q_cmd.opcode == mfmi_pkg::OP_TG_FRAME) begin
              tlen_r  <= (32'(push_len) < FRAME_BYTES) ? push_len + 1'b1 : push_len;
              topen_r <= !q_cmd.last;
            end
            if (q_cmd.opcode == mfmi_pkg::OP_MATCH) begin
              nbz_r   <= q_cmd.nbz;
              rule_r  <= '0;
              state_r <= S_HDR;
            end
          end
        end
        S_HDR: begin
          if (32'(rule_r) == NRULE) begin
            state_r <= S_NOMATCH;
          end else if ((h.rd_len == 7'd0 && h.tg_len == 7'd0) ||
                       (h.rd_len != 7'd0 && 8'(h.rd_len) != 8'(rlen_r)) ||
                       (h.tg_len != 7'd0 && 8'(h.tg_len) != 8'(tlen_r))) begin
            rule_r <= rule_r + 1'b1;
          end else begin
            side_r  <= 1'b0;
            plen_r  <= h.rd_len;
            j_r     <= '0;
            state_r <= S_PISSUE;
          end
        end
        S_PISSUE: begin
          if (j_r == plen_r) begin
            if (!side_r) begin
              side_r <= 1'b1;
              plen_r <= h.tg_len;
              j_r    <= '0;
            end else begin
              k_r     <= '0;
              crc_r   <= 16'h6363;
              state_r <= S_ERD;
            end
          end else if (j_r[6]) begin
            // no pattern byte exists past the slot
            rule_r  <= rule_r + 1'b1;
            state_r <= S_HDR;
          end else begin
            state_r <= S_PCMP;
          end
        end
        S_PCMP: begin
          if (pmatch) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_PISSUE;
          end else begin
            rule_r  <= rule_r + 1'b1;
            state_r <= S_HDR;
          end
        end
        S_ERD: begin
          if (k_r == h.reply_len) begin
            if (h.crc)                    state_r <= S_CLO;
            else if (h.reply_len == 6'd0) state_r <= S_EMPTY;
            else                          state_r <= S_DONE;
          end else begin
            state_r <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            obyte_r  <= ebyte;
            olast_r  <= (7'(k_r) + 7'd1 == total);
            omatch_r <= 1'b1;
            orule_r  <= 4'(rule_r);
            olen_r   <= total;
            crc_r    <= crc_step(crc_r, ebyte);
            k_r      <= k_r + 1'b1;
            state_r  <= S_ERD;
          end
        end
        S_CLO, S_CHI: begin
          if (out_free) begin
            obyte_r  <= (state_r == S_CLO) ? crc_r[7:0] : crc_r[15:8];
            olast_r  <= (state_r == S_CHI);
            omatch_r <= 1'b1;
            orule_r  <= 4'(rule_r);
            olen_r   <= total;
            state_r  <= (state_r == S_CLO) ? S_CHI : S_DONE;
          end
        end
        S_EMPTY, S_NOMATCH: begin
          if (out_free) begin
            obyte_r  <= 8'd0;
            olast_r  <= 1'b1;
            omatch_r <= (state_r == S_EMPTY);
            orule_r  <= (state_r == S_EMPTY) ? 4'(rule_r) : 4'd0;
            olen_r   <= 7'd0;
            state_r  <= (state_r == S_EMPTY) ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          // emitted reply becomes the reader frame
          rlen_r  <= (32'(total) > FRAME_BYTES) ? FL'(FRAME_BYTES) : FL'(total);
          ropen_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = ovalid_r;
  assign out_frame_byte   = obyte_r;
  assign out_last_res     = olast_r;
  assign out_matched      = omatch_r;
  assign out_matched_rule = orule_r;
  assign out_frame_length = olen_r;

endmodule

[hw/rtl/masked_frame_match_inserter.sv]
// ----------------------------------------------------------------------------
// masked_frame_match_inserter
// Rule table with nibble-masked frame matching and reply insertion.
// ----------------------------------------------------------------------------
// Words enter on the in_ channel (valid/ready). Header, reply, pattern and
// frame words are executed as they leave the queue and give no result; a
// two-word queue sits in front of the executor, so in_ready stays high while
// the executor walks until two words are waiting.
// A match word leaves the queue, then walks the rules in order: one S_HDR
// state per header, and for a rule whose lengths fit, an S_PISSUE and an
// S_PCMP state per compared pattern byte (registered memory read, compare)
// plus an S_PISSUE state to end each of its two patterns. The first matching
// rule then sends its reply through S_ERD (reply memory read) and S_EOUT
// (output load) per byte, then S_CLO and S_CHI for the CRC bytes, then S_DONE.
// No match gives a single result word with every field zero but last_res,
// loaded in S_NOMATCH after the last header is visited.
// Results leave from an output register on the out_ channel; while it is full
// and out_ready is low, emitting states hold; the queue takes up to two words.
// Reset clears the rule headers, the frame lengths and all handshake state;
// reply, pattern and frame memories hold nothing defined until written.
// ----------------------------------------------------------------------------
module masked_frame_match_inserter #(
  parameter int RULE_COUNT  = 16,
  parameter int FRAME_BYTES = 64,
  parameter int REPLY_BYTES = 62
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [3:0] in_rule_index,
  input  logic [5:0] in_position,
  input  logic [7:0] in_value,
  input  logic       in_ignore_high_nibble,
  input  logic       in_ignore_low_nibble,
  input  logic [6:0] in_reader_pattern_length,
  input  logic [6:0] in_tag_pattern_length,
  input  logic       in_append_crc,
  input  logic       in_fix_block_number,
  input  logic       in_last,
  input  logic       in_next_block_zero,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic       out_last_res,
  output logic       out_matched,
  output logic [3:0] out_matched_rule,
  output logic [6:0] out_frame_length
);

  // only sixteen rules are addressable
  localparam int NRULE = (RULE_COUNT < 16) ? RULE_COUNT : 16;

  mfmi_pkg::cmd_t in_cmd;
  mfmi_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_pop;

  assign in_cmd = '{
    opcode:     in_opcode,
    rule_index: in_rule_index,
    position:   in_position,
    value:      in_value,
    ign_hi:     in_ignore_high_nibble,
    ign_lo:     in_ignore_low_nibble,
    rd_len:     in_reader_pattern_length,
    tg_len:     in_tag_pattern_length,
    crc:        in_append_crc,
    fix:        in_fix_block_number,
    last:       in_last,
    nbz:        in_next_block_zero
  };

  mfmi_front #(
    .NRULE (NRULE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  mfmi_back #(
    .NRULE       (NRULE),
    .FRAME_BYTES (FRAME_BYTES),
    .REPLY_BYTES (REPLY_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_last_res     (out_last_res),
    .out_matched      (out_matched),
    .out_matched_rule (out_matched_rule),
    .out_frame_length (out_frame_length)
  );

endmodule

[dv/tb_masked_frame_match_inserter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_frame_match_inserter
// Self-checking bench for the masked frame match inserter: rule, frame and
// match words are sent on the in_ channel, the replies are predicted in the bench
// and every reply word on the out_ channel is compared field by field.
// ----------------------------------------------------------------------------
module tb_masked_frame_match_inserter;

  localparam int  RULES      = 16;
  localparam int  FRAME_MAX  = 64;
  localparam int  REPLY_MAX  = 62;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN_CYCLES = 40;

  typedef struct {
    bit [7:0] fbyte;
    bit       lst;
    bit       hit;
    bit [3:0] rule;
    bit [6:0] flen;
  } reply_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic [3:0] in_rule_index = '0;
  logic [5:0] in_position = '0;
  logic [7:0] in_value = '0;
  logic in_ignore_high_nibble = 1'b0;
  logic in_ignore_low_nibble = 1'b0;
  logic [6:0] in_reader_pattern_length = '0;
  logic [6:0] in_tag_pattern_length = '0;
  logic in_append_crc = 1'b0;
  logic in_fix_block_number = 1'b0;
  logic in_last = 1'b0;
  logic in_next_block_zero = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_frame_byte;
  logic out_last_res;
  logic out_matched;
  logic [3:0] out_matched_rule;
  logic [6:0] out_frame_length;

  masked_frame_match_inserter dut (.*);

  // bench copy of the block state
  bit [6:0] hdr_reply_len [RULES];
  bit [6:0] hdr_rd_len [RULES];
  bit [6:0] hdr_tg_len [RULES];
  bit       hdr_crc [RULES];
  bit       hdr_fix [RULES];
  bit [7:0] reply_mem [RULES*64];
  bit [9:0] rd_pat [RULES*64];
  bit [9:0] tg_pat [RULES*64];
  bit       reply_seen [RULES*64];
  bit       rd_pat_seen [RULES*64];
  bit       tg_pat_seen [RULES*64];
  bit [7:0] rd_frame [FRAME_MAX];
  bit [7:0] tg_frame [FRAME_MAX];
  int       rd_flen, tg_flen;
  bit       rd_open, tg_open;

  reply_word_t pending_replies[$];
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int errors = 0;
  int words_sent = 0;
  int matches_sent = 0;
  int replies_checked = 0;
  int hits_seen = 0;
  int cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_replies.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready = ($urandom_range(99) >= out_idle_pct);

  function automatic bit [15:0] crc_a(input bit [7:0] d[66], input int n);
    bit [15:0] crc;
    bit [7:0] ch;
    crc = 16'h6363;
    for (int i = 0; i < n; i++) begin
      ch = d[i] ^ crc[7:0];
      ch = ch ^ (ch << 4);
      crc = (crc >> 8) ^ ({8'h00, ch} << 8) ^ ({8'h00, ch} << 3) ^ ({8'h00, ch} >> 4);
    end
    return crc;
  endfunction

  function automatic bit pattern_hit(input bit tag_side, input int r, input int len);
    bit [9:0] p;
    bit [7:0] b;
    for (int j = 0; j < len; j++) begin
      if (j >= 64) return 1'b0;
      p = tag_side ? tg_pat[r*64+j] : rd_pat[r*64+j];
      b = tag_side ? tg_frame[j] : rd_frame[j];
      if (p[8]) b &= 8'h0F;
      if (p[9]) b &= 8'hF0;
      if (b != p[7:0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_frame_byte(input bit tag_side, input bit [7:0] v,
                                          input bit lst);
    if (tag_side) begin
      if (!tg_open) tg_flen = 0;
      if (tg_flen < FRAME_MAX) tg_frame[tg_flen++] = v;
      tg_open = !lst;
    end else begin
      if (!rd_open) rd_flen = 0;
      if (rd_flen < FRAME_MAX) rd_frame[rd_flen++] = v;
      rd_open = !lst;
    end
  endfunction

  // work out the reply words that one accepted word causes
  function automatic void predict_replies(input mfmi_pkg::cmd_t c);
    bit [7:0] buf_b [66];
    bit [15:0] crc;
    int n, total;
    reply_word_t w;
    case (c.opcode)
      mfmi_pkg::OP_HEADER: begin
        hdr_reply_len[c.rule_index] = (c.value > REPLY_MAX) ? 7'(REPLY_MAX) : 7'(c.value);
        hdr_rd_len[c.rule_index] = c.rd_len;
        hdr_tg_len[c.rule_index] = c.tg_len;
        hdr_crc[c.rule_index] = c.crc;
        hdr_fix[c.rule_index] = c.fix;
      end
      mfmi_pkg::OP_REPLY: reply_mem[c.rule_index*64+c.position] = c.value;
      mfmi_pkg::OP_RD_PAT: rd_pat[c.rule_index*64+c.position] = {c.ign_lo, c.ign_hi, c.value};
      mfmi_pkg::OP_TG_PAT: tg_pat[c.rule_index*64+c.position] = {c.ign_lo, c.ign_hi, c.value};
      mfmi_pkg::OP_RD_FRAME: push_frame_byte(1'b0, c.value, c.last);
      mfmi_pkg::OP_TG_FRAME: push_frame_byte(1'b1, c.value, c.last);
      mfmi_pkg::OP_MATCH: begin
        for (int r = 0; r < RULES; r++) begin
          if (hdr_rd_len[r] == 0 && hdr_tg_len[r] == 0) continue;
          if (hdr_rd_len[r] != 0 && rd_flen != hdr_rd_len[r]) continue;
          if (hdr_tg_len[r] != 0 && tg_flen != hdr_tg_len[r]) continue;
          if (!pattern_hit(1'b0, r, hdr_rd_len[r])) continue;
          if (!pattern_hit(1'b1, r, hdr_tg_len[r])) continue;
          n = hdr_reply_len[r];
          for (int k = 0; k < n; k++) buf_b[k] = reply_mem[r*64+k];
          if (hdr_fix[r] && n > 0)
            buf_b[0] = c.nbz ? ((buf_b[0] & 8'hFE) | 8'h02) : (buf_b[0] | 8'h03);
          total = n;
          if (hdr_crc[r]) begin
            crc = crc_a(buf_b, n);
            buf_b[n] = crc[7:0];
            buf_b[n+1] = crc[15:8];
            total = n + 2;
          end
          if (total == 0) begin
            w = '{fbyte: 8'h00, lst: 1'b1, hit: 1'b1, rule: 4'(r), flen: 7'd0};
            pending_replies.push_back(w);
          end
          for (int k = 0; k < total; k++) begin
            w = '{fbyte: buf_b[k], lst: (k + 1 == total), hit: 1'b1, rule: 4'(r),
                  flen: 7'(total)};
            pending_replies.push_back(w);
          end
          rd_flen = (total > FRAME_MAX) ? FRAME_MAX : total;
          for (int k = 0; k < rd_flen; k++) rd_frame[k] = buf_b[k];
          rd_open = 1'b0;
          return;
        end
        w = '{fbyte: 8'h00, lst: 1'b1, hit: 1'b0, rule: 4'd0, flen: 7'd0};
        pending_replies.push_back(w);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
  endtask

  always @(posedge clk) begin
    reply_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("unexpected reply word at %0t", $realtime);
      end else begin
        w = pending_replies.pop_front();
        replies_checked++;
        if (out_matched && out_last_res) hits_seen++;
        if (out_frame_byte !== w.fbyte) report_mismatch("frame_byte", out_frame_byte, w.fbyte);
        if (out_last_res !== w.lst) report_mismatch("last_res", out_last_res, w.lst);
        if (out_matched !== w.hit) report_mismatch("matched", out_matched, w.hit);
        if (out_matched_rule !== w.rule)
          report_mismatch("matched_rule", out_matched_rule, w.rule);
        if (out_frame_length !== w.flen)
          report_mismatch("frame_length", out_frame_length, w.flen);
      end
    end
  end

  // send one word; valid stays up afterwards until the next call decides
  task automatic send_word(input mfmi_pkg::cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_opcode = c.opcode;
    in_rule_index = c.rule_index;
    in_position = c.position;
    in_value = c.value;
    in_ignore_high_nibble = c.ign_hi;
    in_ignore_low_nibble = c.ign_lo;
    in_reader_pattern_length = c.rd_len;
    in_tag_pattern_length = c.tg_len;
    in_append_crc = c.crc;
    in_fix_block_number = c.fix;
    in_last = c.last;
    in_next_block_zero = c.nbz;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_replies(c);
    words_sent++;
    if (c.opcode == mfmi_pkg::OP_MATCH) matches_sent++;
  endtask

  function automatic mfmi_pkg::cmd_t random_word(input logic [2:0] op);
    mfmi_pkg::cmd_t c;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    c = raw[$bits(mfmi_pkg::cmd_t)-1:0];
    c.opcode = op;
    return c;
  endfunction

  task automatic write_byte(input logic [2:0] op, input int r, input int pos,
                            input bit [7:0] v, input bit ih, input bit il);
    mfmi_pkg::cmd_t c;
    c = random_word(op);
    c.rule_index = 4'(r);
    c.position = 6'(pos);
    c.value = v;
    c.ign_hi = ih;
    c.ign_lo = il;
    if (op == mfmi_pkg::OP_REPLY) reply_seen[r*64+pos] = 1'b1;
    if (op == mfmi_pkg::OP_RD_PAT) rd_pat_seen[r*64+pos] = 1'b1;
    if (op == mfmi_pkg::OP_TG_PAT) tg_pat_seen[r*64+pos] = 1'b1;
    send_word(c);
  endtask

  // header write; any byte the rule could read is written first
  task automatic write_header(input int r, input bit [7:0] rep, input bit [6:0] rdl,
                              input bit [6:0] tgl, input bit crc, input bit fix);
    mfmi_pkg::cmd_t c;
    int n;
    n = (rep > REPLY_MAX) ? REPLY_MAX : rep;
    for (int k = 0; k < n; k++)
      if (!reply_seen[r*64+k]) write_byte(mfmi_pkg::OP_REPLY, r, k, $urandom, 0, 0);
    for (int k = 0; k < rdl && k < 64; k++)
      if (!rd_pat_seen[r*64+k])
        write_byte(mfmi_pkg::OP_RD_PAT, r, k, $urandom, $urandom, $urandom);
    for (int k = 0; k < tgl && k < 64; k++)
      if (!tg_pat_seen[r*64+k])
        write_byte(mfmi_pkg::OP_TG_PAT, r, k, $urandom, $urandom, $urandom);
    c = random_word(mfmi_pkg::OP_HEADER);
    c.rule_index = 4'(r);
    c.value = rep;
    c.rd_len = rdl;
    c.tg_len = tgl;
    c.crc = crc;
    c.fix = fix;
    send_word(c);
  endtask

  // frame that fits the rule's pattern, ignored nibbles filled at random, one bit flipped if spoil_byte
  task automatic send_frame(input bit tag_side, input int r, input int len,
                            input bit spoil_byte);
    mfmi_pkg::cmd_t c;
    bit [9:0] p;
    int bad;
    bad = (len > 0) ? $urandom_range(len - 1) : 0;
    for (int j = 0; j < len; j++) begin
      c = random_word(tag_side ? mfmi_pkg::OP_TG_FRAME : mfmi_pkg::OP_RD_FRAME);
      if (j < 64) begin
        p = tag_side ? tg_pat[r*64+j] : rd_pat[r*64+j];
        c.value = p[7:0];
        if (p[8]) c.value[7:4] = $urandom;
        if (p[9]) c.value[3:0] = $urandom;
        if (spoil_byte && j == bad) c.value = c.value ^ (8'h01 << $urandom_range(7));
      end
      c.last = (j == len - 1);
      send_word(c);
    end
  endtask

  task automatic send_match(input bit nbz);
    mfmi_pkg::cmd_t c;
    c = random_word(mfmi_pkg::OP_MATCH);
    c.nbz = nbz;
    send_word(c);
  endtask

  // spoil: 0 clean, 1 pattern keeps an ignored nibble, 2 flipped frame bit,
  // 3 frame one byte short
  task automatic rule_case(input int r, input bit [7:0] rep, input int rdl, input int tgl,
                           input bit crc, input bit fix, input bit nbz, input int spoil);
    bit [7:0] v;
    bit ih, il;
    int n;
    n = (rep > REPLY_MAX) ? REPLY_MAX : rep;
    for (int k = 0; k < n; k++) write_byte(mfmi_pkg::OP_REPLY, r, k, $urandom, 0, 0);
    for (int side = 0; side < 2; side++)
      for (int k = 0; k < ((side ? tgl : rdl) < 64 ? (side ? tgl : rdl) : 64); k++) begin
        v = $urandom;
        ih = ($urandom_range(3) == 0);
        il = ($urandom_range(3) == 0);
        if (spoil != 1) begin
          if (ih) v[7:4] = 0;
          if (il) v[3:0] = 0;
        end
        write_byte(side ? mfmi_pkg::OP_TG_PAT : mfmi_pkg::OP_RD_PAT, r, k, v, ih, il);
      end
    write_header(r, rep, 7'(rdl), 7'(tgl), crc, fix);
    send_frame(1'b0, r, (rdl > 0) ? rdl - (spoil == 3) : $urandom_range(1, 4), spoil == 2);
    send_frame(1'b1, r, (tgl > 0) ? tgl : $urandom_range(1, 4), 1'b0);
    send_match(nbz);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_match_after_reset();
    send_match(1'b0);
    settle();
  endtask

  task automatic test_directed_rules();
    rule_case(0, 8'd255, 1, 0, 1'b1, 1'b1, 1'b1, 0);   // reply saturated, crc fills frame
    rule_case(15, 8'd0, 0, 2, 1'b0, 1'b1, 1'b0, 0);    // empty reply
    rule_case(14, 8'd0, 0, 3, 1'b1, 1'b1, 1'b0, 0);    // crc only, no reply byte to fix
    rule_case(3, 8'd4, 2, 2, 1'b0, 1'b1, 1'b0, 0);
    rule_case(4, 8'd3, 3, 0, 1'b1, 1'b0, 1'b1, 1);     // masked nibble left set
    write_byte(mfmi_pkg::OP_REPLY, 15, 63, 8'hFF, 1, 1);
    write_byte(mfmi_pkg::OP_RD_PAT, 15, 63, 8'hFF, 1, 1);
    write_header(5, 8'd2, 7'd100, 7'd0, 1'b0, 1'b0);   // pattern longer than any frame
    send_frame(1'b0, 5, 70, 1'b0);                     // overflow, kept at 64 bytes
    send_match(1'b1);
    write_header(5, 8'd0, 7'd0, 7'd0, 1'b0, 1'b0);     // rule switched off
    settle();
  endtask

  task automatic test_random_traffic(input int words);
    int stop_at;
    int pick;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        rule_case($urandom_range(RULES - 1),
                  ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(8),
                  ($urandom_range(20) == 0) ? 64 : $urandom_range(4),
                  ($urandom_range(20) == 0) ? $urandom_range(65, 127) : $urandom_range(4),
                  $urandom, $urandom, $urandom,
                  ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (pick == 7) begin
        write_header($urandom_range(RULES - 1), $urandom, 7'($urandom_range(5)),
                     7'($urandom_range(5)), $urandom, $urandom);
      end else begin
        for (int k = 0; k < 4; k++) begin
          mfmi_pkg::cmd_t c;
          c = random_word(3'($urandom_range(1, 7)));
          if (c.opcode == mfmi_pkg::OP_REPLY) reply_seen[c.rule_index*64+c.position] = 1'b1;
          if (c.opcode == mfmi_pkg::OP_RD_PAT) rd_pat_seen[c.rule_index*64+c.position] = 1'b1;
          if (c.opcode == mfmi_pkg::OP_TG_PAT) tg_pat_seen[c.rule_index*64+c.position] = 1'b1;
          send_word(c);
        end
      end
    end
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct = 21;
    out_idle_pct = 87;
    test_match_after_reset();
    test_directed_rules();
    test_random_traffic(70);
    in_idle_pct = 87;
    out_idle_pct = 21;
    test_random_traffic(70);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_traffic(70);

    $display("sent %0d words including %0d match commands", words_sent, matches_sent);
    $display("checked %0d reply words, %0d matched frames", replies_checked, hits_seen);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors, %0d words never seen", errors, pending_replies.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
